/* rtl/sgos_pkg.sv */
// Package for the segment grid occupancy search block.
// Holds grid sizes, field widths, mode codes, register indices and the sequencer state type.
package sgos_pkg;
  localparam int GridCols = 16;
  localparam int GridRows = 16;
  localparam int Cells    = GridCols * GridRows;
  localparam int AddrW    = $clog2(Cells);
  localparam int CntW     = 9;
  localparam int CountMax = 255;

  typedef enum logic [1:0] {
    MODE_ADD   = 2'd0,
    MODE_FAIL  = 2'd1,
    MODE_PICK  = 2'd2,
    MODE_CLEAR = 2'd3
  } mode_e;

  typedef enum logic [2:0] {
    REG_CELL_W  = 3'd0,
    REG_CELL_H  = 3'd1,
    REG_GAP     = 3'd2,
    REG_SHIFT_X = 3'd3,
    REG_SHIFT_Y = 3'd4
  } reg_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_WALK_RD,
    ST_WALK_WR,
    ST_CNT,
    ST_DIV,
    ST_SEL,
    ST_REG_X,
    ST_REG_Y,
    ST_DONE
  } state_e;
endpackage

/* rtl/segment_grid_occupancy_search_top.sv */
// Top level of the segment grid occupancy search block.
// Holds the count memory, the configuration registers, the sequencer and one shared multiplier.
// Uses sgos_pkg.
//
// Each transaction gives exactly one result, shown for one cycle on done_o;
// the receiver cannot stall. Clear sweeps every cell of the grid. A segment
// does a read-modify-write of each visited cell in the count memory, which
// has one write port and one read port. A pick counts empty inner cells
// over the memory read port, runs restoring division for the modulo,
// locates the cell and does a multiply-add for the region. After reset the
// grid is swept clear, during which busy is high.
module segment_grid_occupancy_search_top (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [2:0]          cfg_idx_i,
  input  logic [10:0]         cfg_data_i,
  input  logic                start,
  output logic                busy,
  input  logic [1:0]          mode_i,
  input  logic [3:0]          start_x_i,
  input  logic [3:0]          start_y_i,
  input  logic [3:0]          end_x_i,
  input  logic [3:0]          end_y_i,
  input  logic [15:0]         random_value_i,
  output logic                done_o,
  output logic                found_o,
  output logic [3:0]          cell_col_o,
  output logic [3:0]          cell_row_o,
  output logic signed [14:0]  region_x_o,
  output logic signed [14:0]  region_y_o,
  output logic signed [11:0]  region_w_o,
  output logic signed [11:0]  region_h_o
);
  localparam int AW = sgos_pkg::AddrW;
  localparam int CW = sgos_pkg::CntW;
  localparam logic [CW-1:0] FailMark = '1;

  logic [CW-1:0] mem_q [sgos_pkg::Cells];
  logic [CW-1:0] rd_q;

  logic [10:0] cw_q, ch_q;
  logic [8:0]  gap_q;
  logic signed [10:0] ox_q, oy_q;

  sgos_pkg::state_e state_q, state_d;
  logic [AW:0]   addr_q, addr_d;
  logic [4:0]    x_q, x_d, y_q, y_d, ex_q, ex_d, ey_q, ey_d;
  logic signed [6:0] err_q, err_d;
  logic [4:0]    dx_q, dx_d, dy_q, dy_d;
  logic          sx_q, sx_d, sy_q, sy_d, ph_q, ph_d;
  logic [AW:0]   k_q, k_d;
  logic [15:0]   rem_q, rem_d;
  logic [4:0]    it_q, it_d;
  logic [15:0]   rnd_q, rnd_d;
  logic [3:0]    col_q, col_d, row_q, row_d;
  logic signed [14:0] rx_q, rx_d, ry_q, ry_d;
  logic          found_q, found_d, done_q, done_d;
  logic          state_fail_q;
  logic          boot_q;

  logic          we;
  logic [AW-1:0] wa, ra;
  logic [CW-1:0] wd;

  logic [AW:0] paddr;
  logic [3:0] acol, arow;
  logic inner;
  logic signed [7:0] e2;
  logic [16:0] trial;
  logic signed [22:0] prod;
  logic [10:0] mul_a;
  logic [3:0]  mul_b;

  assign busy = (state_q != sgos_pkg::ST_IDLE);
  assign paddr = addr_q - 1'b1;
  assign acol = paddr[AW-1:AW/2];
  assign arow = paddr[AW/2-1:0];
  assign inner = (acol != 4'd0) && (acol != 4'(sgos_pkg::GridCols-1)) &&
                 (arow != 4'd0) && (arow != 4'(sgos_pkg::GridRows-1));
  assign e2 = 8'(err_q) <<< 1;
  assign trial = {rem_q, rnd_q[15]} - {8'd0, k_q};
  assign mul_a = (state_q == sgos_pkg::ST_REG_X) ? cw_q : ch_q;
  assign mul_b = (state_q == sgos_pkg::ST_REG_X) ? col_q : row_q;
  assign prod = 23'(signed'({1'b0, mul_a}) * signed'({1'b0, mul_b}));

  always_ff @(posedge clk_i) begin
    if (we) mem_q[wa] <= wd;
    rd_q <= mem_q[ra];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cw_q <= 11'd64; ch_q <= 11'd64; gap_q <= '0;
      ox_q <= -11'sd32; oy_q <= -11'sd32;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        sgos_pkg::REG_CELL_W:  cw_q <= cfg_data_i;
        sgos_pkg::REG_CELL_H:  ch_q <= cfg_data_i;
        sgos_pkg::REG_GAP:     gap_q <= cfg_data_i[8:0];
        sgos_pkg::REG_SHIFT_X: ox_q <= cfg_data_i;
        sgos_pkg::REG_SHIFT_Y: oy_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sgos_pkg::ST_CLEAR;
      addr_q <= '0;
      done_q <= 1'b0;
    end else begin
      state_q <= state_d;
      addr_q <= addr_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) boot_q <= 1'b1;
    else if (state_q == sgos_pkg::ST_CLEAR &&
             addr_q == (AW+1)'(sgos_pkg::Cells - 1)) boot_q <= 1'b0;
  end

  always_ff @(posedge clk_i) begin
    x_q <= x_d; y_q <= y_d; ex_q <= ex_d; ey_q <= ey_d;
    err_q <= err_d; dx_q <= dx_d; dy_q <= dy_d;
    sx_q <= sx_d; sy_q <= sy_d; ph_q <= ph_d;
    k_q <= k_d; rem_q <= rem_d; it_q <= it_d; rnd_q <= rnd_d;
    col_q <= col_d; row_q <= row_d; rx_q <= rx_d; ry_q <= ry_d;
    found_q <= found_d;
  end

  always_comb begin
    state_d = state_q;
    addr_d = addr_q;
    x_d = x_q; y_d = y_q; ex_d = ex_q; ey_d = ey_q;
    err_d = err_q; dx_d = dx_q; dy_d = dy_q;
    sx_d = sx_q; sy_d = sy_q; ph_d = ph_q;
    k_d = k_q; rem_d = rem_q; it_d = it_q; rnd_d = rnd_q;
    col_d = col_q; row_d = row_q; rx_d = rx_q; ry_d = ry_q;
    found_d = found_q;
    done_d = 1'b0;
    case (state_q)
      sgos_pkg::ST_IDLE: begin
        if (start) begin
          found_d = 1'b0; col_d = '0; row_d = '0; rx_d = '0; ry_d = '0;
          x_d = {1'b0, start_x_i}; y_d = {1'b0, start_y_i};
          ex_d = {1'b0, end_x_i}; ey_d = {1'b0, end_y_i};
          sx_d = start_x_i < end_x_i; sy_d = start_y_i < end_y_i;
          dx_d = (end_x_i > start_x_i) ? 5'(end_x_i - start_x_i)
                                       : 5'(start_x_i - end_x_i);
          dy_d = (end_y_i > start_y_i) ? 5'(end_y_i - start_y_i)
                                       : 5'(start_y_i - end_y_i);
          rnd_d = random_value_i;
          addr_d = '0;
          k_d = '0;
          ph_d = 1'b0;
          case (sgos_pkg::mode_e'(mode_i))
            sgos_pkg::MODE_ADD:   state_d = sgos_pkg::ST_WALK_RD;
            sgos_pkg::MODE_FAIL:  state_d = sgos_pkg::ST_DONE;
            sgos_pkg::MODE_PICK:  state_d = sgos_pkg::ST_CNT;
            sgos_pkg::MODE_CLEAR: state_d = sgos_pkg::ST_CLEAR;
            default:              state_d = sgos_pkg::ST_DONE;
          endcase
          err_d = 7'(signed'({1'b0, dx_d})) - 7'(signed'({1'b0, dy_d}));
        end
      end
      sgos_pkg::ST_CLEAR: begin
        addr_d = addr_q + 1'b1;
        if (addr_q == (AW+1)'(sgos_pkg::Cells - 1)) begin
          state_d = boot_q ? sgos_pkg::ST_IDLE : sgos_pkg::ST_DONE;
        end
      end
      sgos_pkg::ST_WALK_RD: state_d = sgos_pkg::ST_WALK_WR;
      sgos_pkg::ST_WALK_WR: begin
        if (x_q == ex_q && y_q == ey_q && !ph_q) begin
          state_d = sgos_pkg::ST_DONE;
        end else begin
          state_d = sgos_pkg::ST_WALK_RD;
          if (!ph_q) begin
            if (e2 > -8'(signed'({1'b0, dy_q}))) begin
              err_d = err_q - 7'(signed'({1'b0, dy_q}));
              x_d = sx_q ? x_q + 1'b1 : x_q - 1'b1;
              ph_d = e2 < 8'(signed'({1'b0, dx_q}));
            end else begin
              err_d = err_q + 7'(signed'({1'b0, dx_q}));
              y_d = sy_q ? y_q + 1'b1 : y_q - 1'b1;
            end
          end else begin
            ph_d = 1'b0;
            err_d = err_q + 7'(signed'({1'b0, dx_q}));
            y_d = sy_q ? y_q + 1'b1 : y_q - 1'b1;
          end
        end
      end
      sgos_pkg::ST_CNT: begin
        addr_d = addr_q + 1'b1;
        ph_d = 1'b1;
        if (ph_q && inner && rd_q == '0) k_d = k_q + 1'b1;
        if (addr_q == (AW+1)'(sgos_pkg::Cells)) begin
          if (k_d == '0) state_d = sgos_pkg::ST_DONE;
          else begin
            state_d = sgos_pkg::ST_DIV;
            rem_d = '0; it_d = '0;
          end
        end
      end
      sgos_pkg::ST_DIV: begin
        rnd_d = {rnd_q[14:0], 1'b0};
        rem_d = trial[16] ? {rem_q[14:0], rnd_q[15]} : trial[15:0];
        it_d = it_q + 1'b1;
        if (it_q == 5'd15) begin
          state_d = sgos_pkg::ST_SEL;
          addr_d = '0; ph_d = 1'b0; k_d = '0;
        end
      end
      sgos_pkg::ST_SEL: begin
        addr_d = addr_q + 1'b1;
        ph_d = 1'b1;
        if (ph_q && inner && rd_q == '0) begin
          if (16'(k_q) == rem_q) begin
            found_d = 1'b1;
            col_d = acol;
            row_d = arow;
            state_d = sgos_pkg::ST_REG_X;
          end
          k_d = k_q + 1'b1;
        end
      end
      sgos_pkg::ST_REG_X: begin
        rx_d = 15'(prod) + 15'(ox_q) + 15'({1'b0, gap_q});
        state_d = sgos_pkg::ST_REG_Y;
      end
      sgos_pkg::ST_REG_Y: begin
        ry_d = 15'(prod) + 15'(oy_q) + 15'({1'b0, gap_q});
        state_d = sgos_pkg::ST_DONE;
      end
      sgos_pkg::ST_DONE: begin
        done_d = 1'b1;
        state_d = sgos_pkg::ST_IDLE;
      end
      default: state_d = sgos_pkg::ST_IDLE;
    endcase
  end

  logic [CW-1:0] inc;
  always_comb begin
    inc = (rd_q == FailMark) ? CW'(1) :
          (rd_q < CW'(sgos_pkg::CountMax)) ? rd_q + 1'b1 : rd_q;
    we = 1'b0;
    wa = addr_q[AW-1:0];
    wd = '0;
    ra = {x_q[3:0], y_q[3:0]};
    case (state_q)
      sgos_pkg::ST_CLEAR: begin
        we = 1'b1;
      end
      sgos_pkg::ST_WALK_WR: begin
        we = 1'b1; wa = {x_q[3:0], y_q[3:0]}; wd = inc;
      end
      sgos_pkg::ST_DONE: begin
        we = !found_q && !done_q && state_fail_q;
        wa = {x_q[3:0], y_q[3:0]}; wd = FailMark;
      end
      sgos_pkg::ST_CNT, sgos_pkg::ST_SEL: begin
        ra = addr_q[AW-1:0];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_fail_q <= 1'b0;
    else if (state_q == sgos_pkg::ST_IDLE && start)
      state_fail_q <= (mode_i == sgos_pkg::MODE_FAIL);
    else if (state_q == sgos_pkg::ST_DONE) state_fail_q <= 1'b0;
  end

  assign done_o     = done_q;
  assign found_o    = found_q;
  assign cell_col_o = col_q;
  assign cell_row_o = row_q;
  assign region_x_o = rx_q;
  assign region_y_o = ry_q;
  assign region_w_o = found_q ? 12'({1'b0, cw_q}) - 12'({gap_q, 1'b0}) : '0;
  assign region_h_o = found_q ? 12'({1'b0, ch_q}) - 12'({gap_q, 1'b0}) : '0;
endmodule
